// ----- design/pip_pkg.sv -----
package pip_pkg;

  // Coordinate and arithmetic widths
  localparam int COORD_WIDTH = 24;
  localparam int DIFF_W      = COORD_WIDTH + 1;      // corner minus point
  localparam int CROSS_W     = 2 * DIFF_W;           // cross product component
  localparam int SPLIT_W     = DIFF_W;               // low slice of a cross component
  localparam int MUL_W       = DIFF_W + 1;           // multiplier operand
  localparam int PROD_W      = 2 * MUL_W;
  localparam int TRIPLE_W    = 3 * DIFF_W + 2;       // triple product
  localparam int SUM_W       = TRIPLE_W + 2;         // sum of three triples
  localparam int SLOT_W      = 12;
  localparam int FACES_W     = 11;
  localparam int CFG_DATA_W  = 24;
  localparam int CFG_IDX_W   = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Z = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FACES    = 2'd3;

  // Request kinds
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic       load_wr;
    logic       query_start;
    logic       rd_en;
    logic [1:0] rd_k;
    logic       cap_en;
    logic [1:0] cap_k;
    logic       op_en;
    logic       op_dot;
    logic [1:0] op_j;
    logic [1:0] op_i;
    logic       op_h;
    logic       sum_en;
    logic       decide_en;
    logic       out_load;
  } pip_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic faces_zero;
    logic last_face;
    logic out_busy;
  } pip_sts_t;

  // Index step modulo three
  function automatic logic [1:0] next3(input logic [1:0] v);
    return (v == 2'd2) ? 2'd0 : v + 2'd1;
  endfunction

endpackage

// ----- design/pip_req_if.sv -----
interface pip_req_if import pip_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic                          req_type;
  logic [SLOT_W-1:0]             corner_slot;
  logic signed [COORD_WIDTH-1:0] pos_x;
  logic signed [COORD_WIDTH-1:0] pos_y;
  logic signed [COORD_WIDTH-1:0] pos_z;

  modport source(output valid, req_type, corner_slot, pos_x, pos_y, pos_z, input ready);
  modport sink(input valid, req_type, corner_slot, pos_x, pos_y, pos_z, output ready);
endinterface

// ----- design/pip_rsp_if.sv -----
interface pip_rsp_if import pip_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               outside_flag;
  logic [FACES_W-1:0] crossing_count;

  modport source(output valid, outside_flag, crossing_count, input ready);
  modport sink(input valid, outside_flag, crossing_count, output ready);
endinterface

// ----- design/point_in_hull_parity_test.sv -----
// Point-in-hull parity test.
// Request channel (req): req_type 0 writes one face corner at corner_slot
// (face*3 + corner); slots at or beyond 3*MAX_FACES are dropped. A load
// returns nothing. req_type 1 queries the point pos_x/y/z.
// Response channel (rsp): one transaction per query with crossing_count, the
// number of hull faces the segment from the point to the configured centre
// crosses inside the triangle, and outside_flag, its parity.
// A query walks faces 0..faces_in_use-1 (capped at MAX_FACES) through one
// shared 26x26 multiplier: 3 corner reads, 18 cross-product terms, 24
// dot-product terms, then drain, sum and decision for each face.
// Requests are taken one at a time; req.ready is high only while idle.
// A finished result waits in an output register; if rsp is stalled when the
// next result is done, the block holds until the register frees.
// Configuration (cfg_we, cfg_index, cfg_data) must be written while idle;
// the block does not enforce it. Reset clears the configuration and control;
// the corner table is not cleared and must be written before a query uses it.
module point_in_hull_parity_test import pip_pkg::*; #(
  parameter int MAX_FACES = 1024
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  pip_req_if.sink               req,
  pip_rsp_if.source             rsp
);

  pip_cmd_t cmd;
  pip_sts_t sts;

  // Controller
  pip_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_type  (req.req_type),
    .in_ready (req.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath
  pip_dp #(
    .MAX_FACES (MAX_FACES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_slot   (req.corner_slot),
    .in_x      (req.pos_x),
    .in_y      (req.pos_y),
    .in_z      (req.pos_z),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .out_flag  (rsp.outside_flag),
    .out_count (rsp.crossing_count)
  );

endmodule

// ----- design/pip_ctrl.sv -----
module pip_ctrl import pip_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  logic     in_type,
  output logic     in_ready,
  input  pip_sts_t sts,
  output pip_cmd_t cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_READ   = 3'd1;
  localparam logic [2:0] S_CROSS  = 3'd2;
  localparam logic [2:0] S_DOT    = 3'd3;
  localparam logic [2:0] S_DRAIN  = 3'd4;
  localparam logic [2:0] S_SUM    = 3'd5;
  localparam logic [2:0] S_DECIDE = 3'd6;
  localparam logic [2:0] S_DONE   = 3'd7;

  logic [2:0] state, state_next;
  logic [1:0] k, k_next;
  logic [1:0] j, j_next;
  logic [1:0] i, i_next;
  logic       h, h_next;

  // State and step counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      k     <= 2'd0;
      j     <= 2'd0;
      i     <= 2'd0;
      h     <= 1'b0;
    end else begin
      state <= state_next;
      k     <= k_next;
      j     <= j_next;
      i     <= i_next;
      h     <= h_next;
    end
  end

  // Sequencing
  always_comb begin
    state_next = state;
    k_next     = k;
    j_next     = j;
    i_next     = i;
    h_next     = h;
    cmd        = '0;
    cmd.rd_k   = k;
    cmd.cap_k  = k - 2'd1;
    cmd.op_j   = j;
    cmd.op_i   = i;
    cmd.op_h   = h;
    in_ready   = (state == S_IDLE);
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (in_type == REQ_LOAD) begin
            cmd.load_wr = 1'b1;
          end else begin
            cmd.query_start = 1'b1;
            k_next          = 2'd0;
            state_next      = sts.faces_zero ? S_DONE : S_READ;
          end
        end
      end
      S_READ: begin
        // three corner reads; data lands in the following cycle
        cmd.rd_en  = (k != 2'd3);
        cmd.cap_en = (k != 2'd0);
        if (k == 2'd3) begin
          state_next = S_CROSS;
          j_next     = 2'd0;
          i_next     = 2'd0;
          h_next     = 1'b0;
        end else begin
          k_next = k + 2'd1;
        end
      end
      S_CROSS: begin
        cmd.op_en = 1'b1;
        h_next    = ~h;
        if (h) begin
          i_next = next3(i);
          if (i == 2'd2) begin
            j_next = next3(j);
            if (j == 2'd2) begin
              state_next = S_DOT;
            end
          end
        end
      end
      S_DOT: begin
        cmd.op_en  = 1'b1;
        cmd.op_dot = 1'b1;
        h_next     = ~h;
        if (h) begin
          i_next = next3(i);
          if (i == 2'd2) begin
            j_next = j + 2'd1;
            if (j == 2'd3) begin
              state_next = S_DRAIN;
            end
          end
        end
      end
      S_DRAIN: begin
        state_next = S_SUM;
      end
      S_SUM: begin
        cmd.sum_en = 1'b1;
        state_next = S_DECIDE;
      end
      S_DECIDE: begin
        cmd.decide_en = 1'b1;
        k_next        = 2'd0;
        state_next    = sts.last_face ? S_DONE : S_READ;
      end
      S_DONE: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ----- design/pip_dp.sv -----
module pip_dp import pip_pkg::*; #(
  parameter int MAX_FACES = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_data,
  input  logic [SLOT_W-1:0]             in_slot,
  input  logic signed [COORD_WIDTH-1:0] in_x,
  input  logic signed [COORD_WIDTH-1:0] in_y,
  input  logic signed [COORD_WIDTH-1:0] in_z,
  input  pip_cmd_t                      cmd,
  output pip_sts_t                      sts,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_flag,
  output logic [FACES_W-1:0]            out_count
);

  localparam int SLOTS  = 3 * MAX_FACES;
  localparam int ADDR_W = $clog2(SLOTS);
  localparam int FACE_W = $clog2(MAX_FACES + 1);
  localparam int DMN_W  = SUM_W + 1;

  // Configuration registers
  logic signed [COORD_WIDTH-1:0] center [3];
  logic [FACES_W-1:0]            faces_cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      center[0] <= '0;
      center[1] <= '0;
      center[2] <= '0;
      faces_cfg <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CENTER_X: center[0] <= signed'(cfg_data[COORD_WIDTH-1:0]);
        CFG_CENTER_Y: center[1] <= signed'(cfg_data[COORD_WIDTH-1:0]);
        CFG_CENTER_Z: center[2] <= signed'(cfg_data[COORD_WIDTH-1:0]);
        CFG_FACES:    faces_cfg <= cfg_data[FACES_W-1:0];
        default:      faces_cfg <= faces_cfg;
      endcase
    end
  end

  // Corner table
  logic [3*COORD_WIDTH-1:0] mem [SLOTS];
  logic [3*COORD_WIDTH-1:0] rd_data;
  logic [ADDR_W-1:0]        base;
  logic [ADDR_W-1:0]        rd_addr;
  logic                     slot_ok;

  assign slot_ok = 32'(in_slot) < 32'(SLOTS);
  assign rd_addr = base + ADDR_W'(cmd.rd_k);

  always_ff @(posedge clk) begin
    if (cmd.load_wr && slot_ok) begin
      mem[ADDR_W'(in_slot)] <= {in_z, in_y, in_x};
    end
    if (cmd.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Query point, segment vector and corner offsets
  logic signed [COORD_WIDTH-1:0] p_vec [3];
  logic signed [DIFF_W-1:0]      s_vec [3];
  logic signed [DIFF_W-1:0]      a_vec [3][3];

  always_ff @(posedge clk) begin
    if (cmd.query_start) begin
      p_vec[0] <= in_x;
      p_vec[1] <= in_y;
      p_vec[2] <= in_z;
      s_vec[0] <= DIFF_W'(center[0]) - DIFF_W'(in_x);
      s_vec[1] <= DIFF_W'(center[1]) - DIFF_W'(in_y);
      s_vec[2] <= DIFF_W'(center[2]) - DIFF_W'(in_z);
    end
    if (cmd.cap_en) begin
      for (int c = 0; c < 3; c++) begin
        a_vec[cmd.cap_k][c] <= DIFF_W'(signed'(rd_data[c*COORD_WIDTH +: COORD_WIDTH]))
                               - DIFF_W'(p_vec[c]);
      end
    end
  end

  // Operand selection for the shared multiplier
  logic signed [CROSS_W-1:0] cr [3][3];
  logic signed [MUL_W-1:0]   op_a, op_b;
  logic [1:0]                jb, jc, i1, i2, jj;
  logic signed [CROSS_W-1:0] crv;

  always_comb begin
    jb   = next3(cmd.op_j);
    jc   = next3(jb);
    i1   = next3(cmd.op_i);
    i2   = next3(i1);
    jj   = (cmd.op_j == 2'd3) ? 2'd0 : cmd.op_j;
    crv  = cr[jj][cmd.op_i];
    if (cmd.op_dot) begin
      op_a = (cmd.op_j == 2'd3) ? MUL_W'(a_vec[0][cmd.op_i]) : MUL_W'(s_vec[cmd.op_i]);
      op_b = cmd.op_h ? MUL_W'(signed'(crv[CROSS_W-1:SPLIT_W]))
                      : signed'({1'b0, crv[SPLIT_W-1:0]});
    end else begin
      op_a = cmd.op_h ? MUL_W'(a_vec[jb][i2]) : MUL_W'(a_vec[jb][i1]);
      op_b = cmd.op_h ? MUL_W'(a_vec[jc][i1]) : MUL_W'(a_vec[jc][i2]);
    end
  end

  // Multiply stage
  logic signed [PROD_W-1:0] prod_q;
  logic                     v_q, dot_q, h_q;
  logic [1:0]               j_q, i_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_q <= 1'b0;
    end else begin
      v_q <= cmd.op_en;
    end
    prod_q <= op_a * op_b;
    dot_q  <= cmd.op_dot;
    h_q    <= cmd.op_h;
    j_q    <= cmd.op_j;
    i_q    <= cmd.op_i;
  end

  // Accumulate stage
  logic signed [TRIPLE_W-1:0] acc, acc_next, term;
  logic signed [TRIPLE_W-1:0] tr [4];
  logic                       first;

  always_comb begin
    term = TRIPLE_W'(prod_q);
    if (dot_q && h_q) begin
      term = term <<< SPLIT_W;
    end
    if (!dot_q && h_q) begin
      term = -term;
    end
    first    = dot_q ? (i_q == 2'd0 && !h_q) : !h_q;
    acc_next = first ? term : acc + term;
  end

  always_ff @(posedge clk) begin
    if (v_q) begin
      acc <= acc_next;
      if (!dot_q && h_q) begin
        cr[j_q][i_q] <= acc_next[CROSS_W-1:0];
      end
      if (dot_q && h_q && i_q == 2'd2) begin
        tr[j_q] <= acc_next;
      end
    end
  end

  // Denominator and crossing decision
  logic signed [SUM_W-1:0] d;
  logic signed [SUM_W-1:0] nx;
  logic signed [DMN_W-1:0] dmn;
  logic                    d_neg, d_pos, n_neg, n_zero, dmn_neg, dmn_zero;
  logic                    w_neg_all, w_pos_all, hit;

  always_ff @(posedge clk) begin
    if (cmd.sum_en) begin
      d <= SUM_W'(tr[0]) + SUM_W'(tr[1]) + SUM_W'(tr[2]);
    end
  end

  always_comb begin
    nx        = SUM_W'(tr[3]);
    dmn       = DMN_W'(d) - DMN_W'(nx);
    d_neg     = d[SUM_W-1];
    d_pos     = !d_neg && (d != '0);
    n_neg     = nx[SUM_W-1];
    n_zero    = (nx == '0);
    dmn_neg   = dmn[DMN_W-1];
    dmn_zero  = (dmn == '0);
    w_pos_all = !tr[0][TRIPLE_W-1] && !tr[1][TRIPLE_W-1] && !tr[2][TRIPLE_W-1];
    w_neg_all = (tr[0][TRIPLE_W-1] || tr[0] == '0) && (tr[1][TRIPLE_W-1] || tr[1] == '0)
                && (tr[2][TRIPLE_W-1] || tr[2] == '0);
    hit = (d_pos && !n_neg && !dmn_neg && w_pos_all)
          || (d_neg && (n_neg || n_zero) && (dmn_neg || dmn_zero) && w_neg_all);
  end

  // Face walk and crossing count
  logic [FACE_W-1:0] face, count, eff;

  assign eff = (32'(faces_cfg) > 32'(MAX_FACES)) ? FACE_W'(MAX_FACES) : FACE_W'(faces_cfg);

  always_ff @(posedge clk) begin
    if (cmd.query_start) begin
      face  <= '0;
      count <= '0;
      base  <= '0;
    end else if (cmd.decide_en) begin
      face  <= face + FACE_W'(1);
      count <= count + FACE_W'(hit);
      base  <= base + ADDR_W'(3);
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (cmd.out_load) begin
      out_flag  <= count[0];
      out_count <= FACES_W'(count);
    end
  end

  assign sts.faces_zero = (eff == '0);
  assign sts.last_face  = (face == eff - FACE_W'(1));
  assign sts.out_busy   = out_valid && !out_ready;

endmodule

// ----- dv/tb_top.sv -----
module tb_top import pip_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FACE_CAP  = 1024;
  localparam int SLOT_CAP  = 3 * FACE_CAP;

  typedef logic signed [127:0] wide_t;

  typedef struct {
    logic                          kind;
    logic [SLOT_W-1:0]             slot;
    logic signed [COORD_WIDTH-1:0] x;
    logic signed [COORD_WIDTH-1:0] y;
    logic signed [COORD_WIDTH-1:0] z;
  } hull_req_t;

  typedef struct {
    logic               flag;
    logic [FACES_W-1:0] count;
  } crossing_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  pip_req_if req_ch ();
  pip_rsp_if rsp_ch ();

  point_in_hull_parity_test dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  // Shadow copy of the corner table and configuration
  logic signed [COORD_WIDTH-1:0] corner_x [SLOT_CAP];
  logic signed [COORD_WIDTH-1:0] corner_y [SLOT_CAP];
  logic signed [COORD_WIDTH-1:0] corner_z [SLOT_CAP];
  logic signed [COORD_WIDTH-1:0] ctr_x, ctr_y, ctr_z;
  logic [FACES_W-1:0] faces_reg;

  hull_req_t pending_reqs[$];
  crossing_t crossings_expected[$];
  int errors;
  int cycle_cnt;
  logic req_taken;
  logic calm;

  // Scalar triple product a . (b x c)
  function automatic wide_t triple(input wide_t ax, ay, az, bx, by, bz, cx, cy, cz);
    return ax * (by * cz - bz * cy) + ay * (bz * cx - bx * cz) + az * (bx * cy - by * cx);
  endfunction

  function automatic bit face_hit(input int f, input wide_t px, py, pz, sx, sy, sz);
    wide_t a0x, a0y, a0z, a1x, a1y, a1z, a2x, a2y, a2z;
    wide_t w0, w1, w2, d, n;
    a0x = wide_t'(corner_x[3*f]) - px;
    a0y = wide_t'(corner_y[3*f]) - py;
    a0z = wide_t'(corner_z[3*f]) - pz;
    a1x = wide_t'(corner_x[3*f+1]) - px;
    a1y = wide_t'(corner_y[3*f+1]) - py;
    a1z = wide_t'(corner_z[3*f+1]) - pz;
    a2x = wide_t'(corner_x[3*f+2]) - px;
    a2y = wide_t'(corner_y[3*f+2]) - py;
    a2z = wide_t'(corner_z[3*f+2]) - pz;
    w0 = triple(sx, sy, sz, a1x, a1y, a1z, a2x, a2y, a2z);
    w1 = triple(sx, sy, sz, a2x, a2y, a2z, a0x, a0y, a0z);
    w2 = triple(sx, sy, sz, a0x, a0y, a0z, a1x, a1y, a1z);
    n  = triple(a0x, a0y, a0z, a1x, a1y, a1z, a2x, a2y, a2z);
    d  = w0 + w1 + w2;
    // parallel or degenerate face never counts
    if (d == 0) return 1'b0;
    if (d < 0) begin
      d = -d; n = -n; w0 = -w0; w1 = -w1; w2 = -w2;
    end
    if (n < 0 || d - n < 0) return 1'b0;
    return w0 >= 0 && w1 >= 0 && w2 >= 0;
  endfunction

  function automatic crossing_t count_hull_crossings(input hull_req_t q);
    wide_t px, py, pz;
    int faces;
    int cnt;
    crossing_t r;
    px = wide_t'(q.x);
    py = wide_t'(q.y);
    pz = wide_t'(q.z);
    faces = (faces_reg > FACE_CAP) ? FACE_CAP : int'(faces_reg);
    cnt = 0;
    for (int f = 0; f < faces; f++)
      if (face_hit(f, px, py, pz, wide_t'(ctr_x) - px, wide_t'(ctr_y) - py,
                   wide_t'(ctr_z) - pz))
        cnt++;
    r.flag = cnt[0];
    r.count = cnt[FACES_W-1:0];
    return r;
  endfunction

  // Clock and reset
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    rst = 1'b1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
  end

  // Idle-free stretch every so often
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    calm <= (cycle_cnt % 40000) < 8000;
  end

  // Request driver
  always @(negedge clk) begin
    hull_req_t it;
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else if (!req_ch.valid || req_taken) begin
      if (pending_reqs.size() > 0 && (calm || $urandom_range(99) >= 12)) begin
        it = pending_reqs.pop_front();
        req_ch.valid <= 1'b1;
        req_ch.req_type <= it.kind;
        req_ch.corner_slot <= it.slot;
        req_ch.pos_x <= it.x;
        req_ch.pos_y <= it.y;
        req_ch.pos_z <= it.z;
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // Response backpressure
  always @(negedge clk) begin
    rsp_ch.ready <= !rst && (calm || $urandom_range(99) >= 12);
  end

  // Monitor: track accepted requests and check responses
  always @(posedge clk) begin
    hull_req_t q;
    crossing_t e;
    req_taken = 1'b0;
    if (!rst) begin
      if (req_ch.valid && req_ch.ready) begin
        req_taken = 1'b1;
        q.kind = req_ch.req_type;
        q.slot = req_ch.corner_slot;
        q.x = req_ch.pos_x;
        q.y = req_ch.pos_y;
        q.z = req_ch.pos_z;
        if (q.kind == REQ_LOAD) begin
          if (q.slot < SLOT_CAP) begin
            corner_x[q.slot] = q.x;
            corner_y[q.slot] = q.y;
            corner_z[q.slot] = q.z;
          end
        end else begin
          crossings_expected.insert(crossings_expected.size(), count_hull_crossings(q));
        end
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (crossings_expected.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected response: flag=%0d count=%0d",
                     rsp_ch.outside_flag, rsp_ch.crossing_count);
        end else begin
          e = crossings_expected.pop_front();
          if (rsp_ch.outside_flag !== e.flag || rsp_ch.crossing_count !== e.count) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: exp flag=%0d count=%0d, got flag=%0d count=%0d",
                       e.flag, e.count, rsp_ch.outside_flag, rsp_ch.crossing_count);
          end
        end
      end
    end
  end

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_CENTER_X: ctr_x = val;
      CFG_CENTER_Y: ctr_y = val;
      CFG_CENTER_Z: ctr_z = val;
      CFG_FACES:    faces_reg = val[FACES_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_center(input int x, input int y, input int z);
    cfg_write(CFG_CENTER_X, x[CFG_DATA_W-1:0]);
    cfg_write(CFG_CENTER_Y, y[CFG_DATA_W-1:0]);
    cfg_write(CFG_CENTER_Z, z[CFG_DATA_W-1:0]);
  endtask

  task automatic load_corner(input int slot, input int x, input int y, input int z);
    hull_req_t it;
    it.kind = REQ_LOAD;
    it.slot = slot[SLOT_W-1:0];
    it.x = x[COORD_WIDTH-1:0];
    it.y = y[COORD_WIDTH-1:0];
    it.z = z[COORD_WIDTH-1:0];
    pending_reqs.insert(pending_reqs.size(), it);
  endtask

  task automatic query_point(input int x, input int y, input int z);
    hull_req_t it;
    it.kind = REQ_QUERY;
    it.slot = SLOT_W'($urandom_range(4095));
    it.x = x[COORD_WIDTH-1:0];
    it.y = y[COORD_WIDTH-1:0];
    it.z = z[COORD_WIDTH-1:0];
    pending_reqs.insert(pending_reqs.size(), it);
  endtask

  task automatic wait_drained;
    while (pending_reqs.size() > 0 || req_ch.valid || crossings_expected.size() > 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  function automatic int rnd(input int span);
    return $urandom_range(2 * span) - span;
  endfunction

  // Stimulus
  initial begin
    int k, px, py, pz, hx, hy, hz, tn;
    errors = 0;
    cycle_cnt = 0;
    calm = 1'b0;
    req_taken = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    req_ch.valid = 1'b0;
    req_ch.req_type = REQ_LOAD;
    req_ch.corner_slot = '0;
    req_ch.pos_x = '0;
    req_ch.pos_y = '0;
    req_ch.pos_z = '0;
    rsp_ch.ready = 1'b0;
    ctr_x = '0; ctr_y = '0; ctr_z = '0;
    faces_reg = '0;
    @(negedge clk);
    while (rst) @(negedge clk);

    // No faces in use after reset: zero crossings
    query_point(8388607, -8388608, 0);
    // Slots past the table are dropped
    load_corner(SLOT_CAP, 8388607, 8388607, 8388607);
    load_corner(4095, -8388608, -8388608, -8388608);
    wait_drained();

    // Hand-built faces: plain hit, parallel, collinear, extreme corners
    set_center(0, 0, 0);
    cfg_write(CFG_FACES, 24'd4);
    load_corner(0, -1000, -1000, 500);
    load_corner(1, 1000, -1000, 500);
    load_corner(2, 0, 1000, 500);
    load_corner(3, 0, -5, -5);
    load_corner(4, 0, 5, -5);
    load_corner(5, 0, 0, 5000);
    load_corner(6, 1, 1, 1);
    load_corner(7, 2, 2, 2);
    load_corner(8, 3, 3, 3);
    load_corner(9, -8388608, -8388608, -8388608);
    load_corner(10, 8388607, -8388608, 8388607);
    load_corner(11, -8388608, 8388607, 8388607);
    query_point(0, 0, 1000);        // crosses the first face
    query_point(-2000, -2000, 1000); // through a corner
    query_point(0, -2000, 1000);    // through an edge
    query_point(0, 0, 500);         // point on the plane
    query_point(0, 0, 499);         // segment ends short of the plane
    query_point(8388607, 8388607, 8388607);
    query_point(-8388608, -8388608, -8388608);
    wait_drained();

    // Random phases: faces built around the segment, mixed with noise
    for (int ph = 0; ph < 22; ph++) begin
      k = $urandom_range(1, 8);
      if (ph % 7 == 3) set_center(rnd(8388607), rnd(8388607), rnd(8388607));
      else set_center(rnd(4000), rnd(4000), rnd(4000));
      cfg_write(CFG_FACES, 24'(k));
      px = rnd(4000); py = rnd(4000); pz = rnd(4000);
      for (int f = 0; f < k; f++) begin
        tn = $urandom_range(16);
        hx = px + ((int'(ctr_x) - px) * tn) / 16;
        hy = py + ((int'(ctr_y) - py) * tn) / 16;
        hz = pz + ((int'(ctr_z) - pz) * tn) / 16;
        for (int c = 0; c < 3; c++) begin
          if ($urandom_range(9) == 0)
            load_corner(3 * f + c, rnd(8388607), rnd(8388607), rnd(8388607));
          else
            load_corner(3 * f + c, hx + rnd(3000), hy + rnd(3000), hz + rnd(3000));
        end
      end
      for (int n = 0; n < 12; n++) begin
        case ($urandom_range(3))
          0: query_point(rnd(8388607), rnd(8388607), rnd(8388607));
          1: query_point(rnd(5000), rnd(5000), rnd(5000));
          default: query_point(px + rnd(300), py + rnd(300), pz + rnd(300));
        endcase
      end
      wait_drained();
    end

    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  // Hard stop
  initial begin
    #40_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ----- sim.f -----
design/pip_pkg.sv
design/pip_req_if.sv
design/pip_rsp_if.sv
design/pip_ctrl.sv
design/pip_dp.sv
design/point_in_hull_parity_test.sv
dv/tb_top.sv
